@@ rtl/pwoi_pkg.sv @@
// ============================================================================
// pwoi_pkg: shared types and constants of the planar odometry integrator
// Holds the controller states, the multiplier schedule, the command word,
// the configuration record and the fixed-point constants.
// ============================================================================
package pwoi_pkg;

    localparam int ACC_W    = 68;            // accumulator and divider width
    localparam int DIV_RB   = 4;             // quotient bits per divider step
    localparam int DIV_STEPS = ACC_W / DIV_RB;
    localparam int CNT_W    = 6;
    localparam int APB_AW   = 5;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
    localparam logic [13:0]        US_DIV      = 14'd15625;
    localparam logic [63:0]        RATE_SCALE  = 64'd192406520023089232;

    localparam logic [2:0] REG_OFS_X   = 3'd0;
    localparam logic [2:0] REG_OFS_Y   = 3'd1;
    localparam logic [2:0] REG_OFS_Z   = 3'd2;
    localparam logic [2:0] REG_PITCH_C = 3'd3;
    localparam logic [2:0] REG_PITCH_S = 3'd4;

    localparam logic [CNT_W-1:0] VMUL_LEN = 6'd4;
    localparam logic [CNT_W-1:0] DMUL_LEN = 6'd3;
    localparam logic [CNT_W-1:0] HMUL_LEN = 6'd4;
    localparam logic [CNT_W-1:0] OMUL_LEN = 6'd8;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef enum logic [4:0] {
        S_IDLE, S_CLD0, S_ROT0, S_CFIN0, S_VMUL, S_VSAT, S_DMUL, S_DLD, S_DIV,
        S_DFIN, S_HMUL, S_HFIN, S_CLD1, S_ROT1, S_CFIN1, S_OMUL, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        MOP_NONE,
        MOP_VF_C, MOP_VL_S, MOP_VF_S, MOP_VL_C,
        MOP_WX_DT, MOP_WY_DT, MOP_WR_DT,
        MOP_H00, MOP_H01, MOP_H10, MOP_H11,
        MOP_OX_C, MOP_OY_S, MOP_OX_S, MOP_OY_C,
        MOP_CH_MC, MOP_SH_MS, MOP_CH_MS, MOP_SH_MC
    } t_mop;

    typedef struct packed {
        logic       latch_time;
        logic       load_item;
        logic       cor_load;
        logic       cor_step;
        logic       cor_fin;
        logic [4:0] step_idx;
        t_mop       mul_op;
        logic       vsat;
        logic       div_load;
        logic       div_step;
        logic       dfin;
        logic       hfin;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [31:0] ofs_x;
        logic [31:0] ofs_y;
        logic [31:0] ofs_z;
        logic [31:0] pitch_c;
        logic [31:0] pitch_s;
    } t_cfg;

    // Multiplier schedule of each multiply phase.
    function automatic t_mop mop_sched(input t_state st, input logic [2:0] idx);
        t_mop m;
        m = MOP_NONE;
        unique case (st)
            S_VMUL: begin
                case (idx)
                    3'd0: m = MOP_VF_C;
                    3'd1: m = MOP_VL_S;
                    3'd2: m = MOP_VF_S;
                    3'd3: m = MOP_VL_C;
                    default: m = MOP_NONE;
                endcase
            end
            S_DMUL: begin
                case (idx)
                    3'd0: m = MOP_WX_DT;
                    3'd1: m = MOP_WY_DT;
                    3'd2: m = MOP_WR_DT;
                    default: m = MOP_NONE;
                endcase
            end
            S_HMUL: begin
                case (idx)
                    3'd0: m = MOP_H00;
                    3'd1: m = MOP_H01;
                    3'd2: m = MOP_H10;
                    3'd3: m = MOP_H11;
                    default: m = MOP_NONE;
                endcase
            end
            S_OMUL: begin
                case (idx)
                    3'd0: m = MOP_OX_C;
                    3'd1: m = MOP_OY_S;
                    3'd2: m = MOP_OX_S;
                    3'd3: m = MOP_OY_C;
                    3'd4: m = MOP_CH_MC;
                    3'd5: m = MOP_SH_MS;
                    3'd6: m = MOP_CH_MS;
                    default: m = MOP_SH_MC;
                endcase
            end
            default: m = MOP_NONE;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/pwoi_if.sv @@
// ============================================================================
// pwoi_if: valid/ready channels of the planar odometry integrator
// The sample channel and the pose channel, each with source and sink views.
// ============================================================================
interface pwoi_in_if;
    logic               valid;
    logic               ready;
    logic [63:0]        stamp_us;
    logic signed [31:0] velocity_fwd;
    logic signed [31:0] velocity_lat;
    logic signed [31:0] yaw_rate;

    modport source (output valid, stamp_us, velocity_fwd, velocity_lat, yaw_rate,
                    input ready);
    modport sink   (input valid, stamp_us, velocity_fwd, velocity_lat, yaw_rate,
                    output ready);
endinterface

interface pwoi_out_if;
    logic               valid;
    logic               ready;
    logic [63:0]        time_out;
    logic signed [47:0] sensor_pos_x;
    logic signed [47:0] sensor_pos_y;
    logic signed [31:0] sensor_pos_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;

    modport source (output valid, time_out, sensor_pos_x, sensor_pos_y, sensor_pos_z,
                    quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, time_out, sensor_pos_x, sensor_pos_y, sensor_pos_z,
                    quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

@@ rtl/pwoi_cordic.sv @@
// ============================================================================
// pwoi_cordic: one iterative CORDIC lane
// Rotation mode on a 32-bit binary angle, one micro-rotation per i_step cycle.
// ============================================================================
module pwoi_cordic
    import pwoi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_load,
    input  logic [31:0]        i_angle,
    input  logic               i_step,
    input  logic [4:0]         i_idx,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);

    logic signed [33:0] r_x, r_y, r_z;
    logic               r_flip;
    logic signed [33:0] w_za, w_dx, w_dy, w_at, w_xf, w_yf;

    assign w_za = 34'(signed'(i_angle));
    assign w_dx = r_y >>> i_idx;
    assign w_dy = r_x >>> i_idx;
    assign w_at = {2'b00, ATAN_TAB[i_idx]};

    // Angles beyond a quarter turn are folded by a half turn and negated later.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= CORDIC_GAIN;
            r_y <= '0;
            if (w_za > Q30_ONE) begin
                r_z    <= w_za - 34'sd2147483648;
                r_flip <= 1'b1;
            end else if (w_za < -Q30_ONE) begin
                r_z    <= w_za + 34'sd2147483648;
                r_flip <= 1'b1;
            end else begin
                r_z    <= w_za;
                r_flip <= 1'b0;
            end
        end else if (i_step) begin
            if (r_z >= 0) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
        end
    end

    assign w_xf = r_flip ? -r_x : r_x;
    assign w_yf = r_flip ? -r_y : r_y;

    always_comb begin
        if (w_xf > Q30_ONE) begin
            o_cos = 32'(Q30_ONE);
        end else if (w_xf < -Q30_ONE) begin
            o_cos = 32'(-Q30_ONE);
        end else begin
            o_cos = 32'(w_xf);
        end
        if (w_yf > Q30_ONE) begin
            o_sin = 32'(Q30_ONE);
        end else if (w_yf < -Q30_ONE) begin
            o_sin = 32'(-Q30_ONE);
        end else begin
            o_sin = 32'(w_yf);
        end
    end

endmodule

@@ rtl/pwoi_div.sv @@
// ============================================================================
// pwoi_div: iterative floor division by the microsecond scale
// Restoring division of a signed value by 15625, 4 quotient bits per i_step.
// ============================================================================
module pwoi_div
    import pwoi_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic signed [ACC_W-1:0] i_dividend,
    input  logic                   i_step,
    output logic signed [ACC_W-1:0] o_quot
);

    logic [ACC_W-1:0] r_dq, w_dq;
    logic [13:0]      r_rem, w_rem;
    logic [14:0]      w_t;
    logic             r_neg;

    always_comb begin
        w_dq  = r_dq;
        w_rem = r_rem;
        w_t   = '0;
        for (int j = 0; j < DIV_RB; j++) begin
            w_t  = {w_rem, w_dq[ACC_W-1]};
            w_dq = w_dq << 1;
            if (w_t >= {1'b0, US_DIV}) begin
                w_rem   = 14'(w_t - {1'b0, US_DIV});
                w_dq[0] = 1'b1;
            end else begin
                w_rem = w_t[13:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_neg <= i_dividend[ACC_W-1];
            r_dq  <= i_dividend[ACC_W-1] ? ACC_W'(-i_dividend) : ACC_W'(i_dividend);
            r_rem <= '0;
        end else if (i_step) begin
            r_dq  <= w_dq;
            r_rem <= w_rem;
        end
    end

    // A negative dividend rounds toward minus infinity.
    assign o_quot = r_neg ? -signed'(r_dq + ACC_W'(r_rem != '0)) : signed'(r_dq);

endmodule

@@ rtl/pwoi_ctrl.sv @@
// ============================================================================
// pwoi_ctrl: sequencer of the planar odometry integrator
// Walks each sample through rotation, scaling, division and pose phases.
// ============================================================================
module pwoi_ctrl
    import pwoi_pkg::*;
#(
    parameter int CORDIC_STEPS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_seen, r_out_valid;
    logic             w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept && r_seen) n_state = S_CLD0;
            S_CLD0:  n_state = S_ROT0;
            S_ROT0:  if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) n_state = S_CFIN0;
            S_CFIN0: n_state = S_VMUL;
            S_VMUL:  if (r_cnt == VMUL_LEN) n_state = S_VSAT;
            S_VSAT:  n_state = S_DMUL;
            S_DMUL:  if (r_cnt == DMUL_LEN) n_state = S_DLD;
            S_DLD:   n_state = S_DIV;
            S_DIV:   if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_DFIN;
            S_DFIN:  n_state = S_HMUL;
            S_HMUL:  if (r_cnt == HMUL_LEN) n_state = S_HFIN;
            S_HFIN:  n_state = S_CLD1;
            S_CLD1:  n_state = S_ROT1;
            S_ROT1:  if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) n_state = S_CFIN1;
            S_CFIN1: n_state = S_OMUL;
            S_OMUL:  if (r_cnt == OMUL_LEN) n_state = S_OUT;
            S_OUT:   if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        n_cnt = (n_state == r_state) ? r_cnt + 1'b1 : '0;
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_op   = MOP_NONE;
        o_cmd.step_idx = r_cnt[4:0];
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch_time = w_accept;
                o_cmd.load_item  = w_accept && r_seen;
            end
            S_CLD0, S_CLD1:   o_cmd.cor_load = 1'b1;
            S_ROT0, S_ROT1:   o_cmd.cor_step = 1'b1;
            S_CFIN0, S_CFIN1: o_cmd.cor_fin  = 1'b1;
            S_VMUL: if (r_cnt < VMUL_LEN) o_cmd.mul_op = mop_sched(r_state, r_cnt[2:0]);
            S_DMUL: if (r_cnt < DMUL_LEN) o_cmd.mul_op = mop_sched(r_state, r_cnt[2:0]);
            S_HMUL: if (r_cnt < HMUL_LEN) o_cmd.mul_op = mop_sched(r_state, r_cnt[2:0]);
            S_OMUL: if (r_cnt < OMUL_LEN) o_cmd.mul_op = mop_sched(r_state, r_cnt[2:0]);
            S_VSAT: o_cmd.vsat     = 1'b1;
            S_DLD:  o_cmd.div_load = 1'b1;
            S_DIV:  o_cmd.div_step = 1'b1;
            S_DFIN: o_cmd.dfin     = 1'b1;
            S_HFIN: o_cmd.hfin     = 1'b1;
            S_OUT:  o_cmd.out_load = !r_out_valid || i_out_ready;
            default: o_cmd.mul_op  = MOP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_seen      <= r_seen || w_accept;
            r_out_valid <= o_cmd.out_load || (r_out_valid && !i_out_ready);
        end
    end

`ifndef SYNTH
    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_seen) |=> (r_state == S_CLD0))
        else $error("accepted sample did not start the rotation phase");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("pose load did not raise the output valid");

    a_rot_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT0 || r_state == S_ROT1) |-> (r_cnt < CNT_W'(CORDIC_STEPS)))
        else $error("CORDIC step count ran past its end");
`endif

endmodule

@@ rtl/pwoi_dp.sv @@
// ============================================================================
// pwoi_dp: datapath of the planar odometry integrator
// Shared multiplier, two CORDIC lanes, two dividers and the pose state.
// ============================================================================
module pwoi_dp
    import pwoi_pkg::*;
#(
    parameter int ANGLE_BITS = 32,
    parameter int POS_BITS   = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  t_cfg               i_cfg,
    input  logic [63:0]        i_stamp_us,
    input  logic signed [31:0] i_velocity_fwd,
    input  logic signed [31:0] i_velocity_lat,
    input  logic signed [31:0] i_yaw_rate,
    output logic [63:0]        o_time_out,
    output logic signed [47:0] o_sensor_pos_x,
    output logic signed [47:0] o_sensor_pos_y,
    output logic signed [31:0] o_sensor_pos_z,
    output logic signed [31:0] o_quat_w,
    output logic signed [31:0] o_quat_x,
    output logic signed [31:0] o_quat_y,
    output logic signed [31:0] o_quat_z
);

    localparam int HR = 95 - ANGLE_BITS;   // rounding bit of the heading step
    localparam int HS = 96 - ANGLE_BITS;   // shift of the heading step

    logic [63:0]          r_last_time, r_stamp, w_diff;
    logic [31:0]          r_dt, w_dt;
    logic signed [31:0]   r_vf, r_vl, r_wr, r_wx, r_wy;
    logic signed [31:0]   r_c, r_s, r_ch, r_sh, w_c0, w_s0, w_c1, w_s1;
    logic signed [32:0]   w_ma, w_mb;
    logic signed [65:0]   r_prod;
    t_mop                 r_prod_op;
    logic signed [ACC_W-1:0] w_p, w_pr30, r_acc_a, r_acc_b, w_ra, w_rb;
    logic signed [ACC_W-1:0] w_rx, w_ry, w_dx, w_dy;
    logic [63:0]          r_mag, w_pu;
    logic                 r_qneg;
    logic [127:0]         r_hacc, w_hround;
    logic [ANGLE_BITS-1:0] r_heading, w_hstep;
    logic [POS_BITS-1:0]  r_pos_x, r_pos_y;
    logic signed [POS_BITS-1:0] w_sx, w_sy;
    logic signed [31:0]   r_qw, r_qx, r_qy, r_qz;
    logic [31:0]          w_ang, w_half;

    function automatic logic signed [31:0] sat_i32(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(64'sd2147483647)) begin
            return 32'sh7fffffff;
        end else if (v < ACC_W'(-64'sd2147483648)) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    function automatic logic signed [31:0] sat_q30(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(Q30_ONE)) begin
            return 32'(Q30_ONE);
        end else if (v < ACC_W'(-Q30_ONE)) begin
            return 32'(-Q30_ONE);
        end
        return 32'(v);
    endfunction

    // Sample intake: dt is zero when time does not advance, and saturates.
    assign w_diff = i_stamp_us - r_last_time;
    assign w_dt   = (i_stamp_us <= r_last_time) ? '0 :
                    ((w_diff[63:32] != '0) ? '1 : w_diff[31:0]);

    // Heading as a full-scale angle, and its signed half.
    assign w_ang  = 32'({r_heading, 32'd0} >> ANGLE_BITS);
    assign w_half = {w_ang[31], w_ang[31:1]};

    pwoi_cordic u_cor0 (
        .i_clk   (i_clk),
        .i_load  (i_cmd.cor_load),
        .i_angle (w_ang),
        .i_step  (i_cmd.cor_step),
        .i_idx   (i_cmd.step_idx),
        .o_cos   (w_c0),
        .o_sin   (w_s0)
    );

    pwoi_cordic u_cor1 (
        .i_clk   (i_clk),
        .i_load  (i_cmd.cor_load),
        .i_angle (w_half),
        .i_step  (i_cmd.cor_step),
        .i_idx   (i_cmd.step_idx),
        .o_cos   (w_c1),
        .o_sin   (w_s1)
    );

    pwoi_div u_div_x (
        .i_clk      (i_clk),
        .i_load     (i_cmd.div_load),
        .i_dividend (r_acc_a),
        .i_step     (i_cmd.div_step),
        .o_quot     (w_dx)
    );

    pwoi_div u_div_y (
        .i_clk      (i_clk),
        .i_load     (i_cmd.div_load),
        .i_dividend (r_acc_b),
        .i_step     (i_cmd.div_step),
        .o_quot     (w_dy)
    );

    // Operand selection of the shared 33x33 multiplier.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.mul_op)
            MOP_VF_C:  begin w_ma = 33'(r_vf); w_mb = 33'(r_c); end
            MOP_VL_S:  begin w_ma = 33'(r_vl); w_mb = 33'(r_s); end
            MOP_VF_S:  begin w_ma = 33'(r_vf); w_mb = 33'(r_s); end
            MOP_VL_C:  begin w_ma = 33'(r_vl); w_mb = 33'(r_c); end
            MOP_WX_DT: begin w_ma = 33'(r_wx); w_mb = {1'b0, r_dt}; end
            MOP_WY_DT: begin w_ma = 33'(r_wy); w_mb = {1'b0, r_dt}; end
            MOP_WR_DT: begin w_ma = 33'(r_wr); w_mb = {1'b0, r_dt}; end
            MOP_H00: begin w_ma = {1'b0, r_mag[31:0]};  w_mb = {1'b0, RATE_SCALE[31:0]}; end
            MOP_H01: begin w_ma = {1'b0, r_mag[31:0]};  w_mb = {1'b0, RATE_SCALE[63:32]}; end
            MOP_H10: begin w_ma = {1'b0, r_mag[63:32]}; w_mb = {1'b0, RATE_SCALE[31:0]}; end
            MOP_H11: begin w_ma = {1'b0, r_mag[63:32]}; w_mb = {1'b0, RATE_SCALE[63:32]}; end
            MOP_OX_C:  begin w_ma = 33'(signed'(i_cfg.ofs_x)); w_mb = 33'(r_c); end
            MOP_OY_S:  begin w_ma = 33'(signed'(i_cfg.ofs_y)); w_mb = 33'(r_s); end
            MOP_OX_S:  begin w_ma = 33'(signed'(i_cfg.ofs_x)); w_mb = 33'(r_s); end
            MOP_OY_C:  begin w_ma = 33'(signed'(i_cfg.ofs_y)); w_mb = 33'(r_c); end
            MOP_CH_MC: begin w_ma = 33'(r_ch); w_mb = 33'(signed'(i_cfg.pitch_c)); end
            MOP_SH_MS: begin w_ma = 33'(r_sh); w_mb = 33'(signed'(i_cfg.pitch_s)); end
            MOP_CH_MS: begin w_ma = 33'(r_ch); w_mb = 33'(signed'(i_cfg.pitch_s)); end
            MOP_SH_MC: begin w_ma = 33'(r_sh); w_mb = 33'(signed'(i_cfg.pitch_c)); end
            default:   begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_p    = ACC_W'(r_prod);
    assign w_pu   = r_prod[63:0];
    assign w_pr30 = (w_p + ACC_W'(64'sd536870912)) >>> 30;
    assign w_ra   = (r_acc_a + ACC_W'(64'sd536870912)) >>> 30;
    assign w_rb   = (r_acc_b + ACC_W'(64'sd536870912)) >>> 30;
    assign w_rx   = (r_acc_a + ACC_W'(64'sd2097152)) >>> 22;
    assign w_ry   = (r_acc_b + ACC_W'(64'sd2097152)) >>> 22;

    assign w_hround = r_hacc + (128'd1 << HR);
    assign w_hstep  = r_qneg ? -w_hround[HS +: ANGLE_BITS] : w_hround[HS +: ANGLE_BITS];

    assign w_sx = signed'(r_pos_x + w_rx[POS_BITS-1:0]);
    assign w_sy = signed'(r_pos_y + w_ry[POS_BITS-1:0]);

    // Pose state and the multiplier tag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading   <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_last_time <= '0;
            r_prod_op   <= MOP_NONE;
        end else begin
            r_prod_op <= i_cmd.mul_op;
            if (i_cmd.latch_time) begin
                r_last_time <= i_stamp_us;
            end
            if (i_cmd.dfin) begin
                r_pos_x <= r_pos_x + w_dx[POS_BITS-1:0];
                r_pos_y <= r_pos_y + w_dy[POS_BITS-1:0];
            end
            if (i_cmd.hfin) begin
                r_heading <= r_heading + w_hstep;
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (i_cmd.load_item) begin
            r_stamp <= i_stamp_us;
            r_dt    <= w_dt;
            r_vf    <= i_velocity_fwd;
            r_vl    <= i_velocity_lat;
            r_wr    <= i_yaw_rate;
        end
        if (i_cmd.cor_fin) begin
            r_c  <= w_c0;
            r_s  <= w_s0;
            r_ch <= w_c1;
            r_sh <= w_s1;
        end
        if (i_cmd.vsat) begin
            r_wx <= sat_i32(w_ra);
            r_wy <= sat_i32(w_rb);
        end
        // Products are folded in the cycle after they are registered in r_prod.
        case (r_prod_op)
            MOP_VF_C, MOP_OX_C:   r_acc_a <= w_p;
            MOP_VL_S, MOP_OY_S:   r_acc_a <= r_acc_a - w_p;
            MOP_VF_S, MOP_OX_S:   r_acc_b <= w_p;
            MOP_VL_C, MOP_OY_C:   r_acc_b <= r_acc_b + w_p;
            // Rounded division by 15625 after scaling by four.
            MOP_WX_DT: r_acc_a <= (w_p <<< 2) + ACC_W'(64'sd7812);
            MOP_WY_DT: r_acc_b <= (w_p <<< 2) + ACC_W'(64'sd7812);
            MOP_WR_DT: begin
                r_qneg <= w_p < 0;
                r_mag  <= (w_p < 0) ? 64'(-w_p) : 64'(w_p);
            end
            MOP_H00: r_hacc <= {64'd0, w_pu};
            MOP_H01, MOP_H10: r_hacc <= r_hacc + {32'd0, w_pu, 32'd0};
            MOP_H11: r_hacc <= r_hacc + {w_pu, 64'd0};
            MOP_CH_MC: r_qw <= sat_q30(w_pr30);
            MOP_SH_MS: r_qx <= sat_q30(-w_pr30);
            MOP_CH_MS: r_qy <= sat_q30(w_pr30);
            MOP_SH_MC: r_qz <= sat_q30(w_pr30);
            default: r_qneg <= r_qneg;
        endcase
        if (i_cmd.out_load) begin
            o_time_out     <= r_stamp;
            o_sensor_pos_x <= 48'(64'(w_sx));
            o_sensor_pos_y <= 48'(64'(w_sy));
            o_sensor_pos_z <= signed'(i_cfg.ofs_z);
            o_quat_w       <= r_qw;
            o_quat_x       <= r_qx;
            o_quat_y       <= r_qy;
            o_quat_z       <= r_qz;
        end
    end

endmodule

@@ rtl/planar_wheel_odometry_integrator_core.sv @@
// ============================================================================
// planar_wheel_odometry_integrator_core: planar dead-reckoning integrator
// Integrates timestamped body velocity samples into a world pose and
// reports the pose of a pitched sensor mount after every sample but the first.
// ============================================================================
// The block takes one velocity sample at a time. The first sample after reset
// only records its time stamp and produces no transfer on the pose channel.
// The next sample is accepted in the cycle after the pose of the last one is
// loaded into the output register. The work on a sample comprises two passes
// of the two iterative CORDIC lanes (one micro-rotation per cycle each), the
// single shared 33x33 multiplier that forms the nineteen products of a sample
// one per cycle, and the dividers that convert velocity times microseconds to
// meters four quotient bits per cycle. A finished pose waits in the output
// register, so the next sample is still taken and worked on while the pose
// side stalls; its own pose then waits in the sequencer until the output
// register is free. The mount registers are written through the APB-style
// port and must only change while no sample is in flight.
module planar_wheel_odometry_integrator_core
    import pwoi_pkg::*;
#(
    parameter int ANGLE_BITS   = 32,
    parameter int POS_BITS     = 48,
    parameter int CORDIC_STEPS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pwoi_in_if.sink           i_in,
    pwoi_out_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg r_cfg;
    t_cmd w_cmd;
    logic w_wr;

    // Configuration registers, one word each at a 4-byte stride.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ofs_x   <= 32'd0;
            r_cfg.ofs_y   <= 32'd0;
            r_cfg.ofs_z   <= 32'd39322;        // 0.6 m
            r_cfg.pitch_c <= 32'd1065364136;   // cos of half pitch, Q1.30
            r_cfg.pitch_s <= 32'd133868471;    // sin of half pitch, Q1.30
        end else if (w_wr) begin
            unique case (paddr[4:2])
                REG_OFS_X:   r_cfg.ofs_x   <= pwdata;
                REG_OFS_Y:   r_cfg.ofs_y   <= pwdata;
                REG_OFS_Z:   r_cfg.ofs_z   <= pwdata;
                REG_PITCH_C: r_cfg.pitch_c <= pwdata;
                REG_PITCH_S: r_cfg.pitch_s <= pwdata;
                default:     r_cfg <= r_cfg;   // unmapped offsets ignore writes
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_OFS_X:   prdata = r_cfg.ofs_x;
            REG_OFS_Y:   prdata = r_cfg.ofs_y;
            REG_OFS_Z:   prdata = r_cfg.ofs_z;
            REG_PITCH_C: prdata = r_cfg.pitch_c;
            REG_PITCH_S: prdata = r_cfg.pitch_s;
            default:     prdata = '0;
        endcase
    end

    // The sequencer issues one command word per cycle to the datapath.
    pwoi_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (w_cmd)
    );

    // Heading, position, the arithmetic units and the pose output register.
    pwoi_dp #(
        .ANGLE_BITS (ANGLE_BITS),
        .POS_BITS   (POS_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg          (r_cfg),
        .i_stamp_us     (i_in.stamp_us),
        .i_velocity_fwd (i_in.velocity_fwd),
        .i_velocity_lat (i_in.velocity_lat),
        .i_yaw_rate     (i_in.yaw_rate),
        .o_time_out     (o_res.time_out),
        .o_sensor_pos_x (o_res.sensor_pos_x),
        .o_sensor_pos_y (o_res.sensor_pos_y),
        .o_sensor_pos_z (o_res.sensor_pos_z),
        .o_quat_w       (o_res.quat_w),
        .o_quat_x       (o_res.quat_x),
        .o_quat_y       (o_res.quat_y),
        .o_quat_z       (o_res.quat_z)
    );

endmodule

@@ bench/planar_wheel_odometry_integrator_core_chk.sv @@
`timescale 1ns / 1ps
// ============================================================================
// planar_wheel_odometry_integrator_core_chk: pose predictor and comparator
// Watches the sample, pose and mount register channels. It keeps its own
// copy of the integrator state and compares every pose transfer, field by
// field, with the oldest predicted pose.
// ============================================================================
module planar_wheel_odometry_integrator_core_chk
    import pwoi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    pwoi_in_if                sample_ch,
    pwoi_out_if               pose_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_poses_seen
);

    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint HALF_TURN = 64'sd2147483648;

    typedef struct packed {
        logic [63:0] stamp;
        logic [47:0] pos_x;
        logic [47:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] qw;
        logic [31:0] qx;
        logic [31:0] qy;
        logic [31:0] qz;
    } t_pose;

    t_pose       pose_q[$];
    logic [31:0] mount_reg[5];
    logic [31:0] heading;
    logic [47:0] track_x;
    logic [47:0] track_y;
    logic [63:0] last_stamp;
    logic        stamp_seen;
    int          mismatches;
    int          strays;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint round_shift(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    task automatic sin_cos(input logic [31:0] ang, output longint c, output longint s);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'($signed(ang));
        x = 64'sd652032874;
        y = 0;
        flip = 0;
        if (z > ONE_Q30) begin
            z -= HALF_TURN;
            flip = 1;
        end else if (z < -ONE_Q30) begin
            z += HALF_TURN;
            flip = 1;
        end
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_TAB[i]);
            end else begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_TAB[i]);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clip(x, -ONE_Q30, ONE_Q30);
        s = clip(y, -ONE_Q30, ONE_Q30);
    endtask

    // Q16.16 m/s times microseconds to Q24.24 m, rounded to nearest.
    function automatic longint travel(input longint w, input longint dt);
        longint q, a, r;
        q = w * dt;
        a = q / 15625;
        r = q % 15625;
        if (r < 0) begin
            a--;
            r += 15625;
        end
        return a * 4 + (r * 4 + 7812) / 15625;
    endfunction

    // Yaw rate times dt to a binary angle, rounded on the magnitude.
    function automatic logic [31:0] turn(input longint q);
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [63:0]  d;
        mag = (q < 0) ? 64'(-q) : 64'(q);
        prod = {64'd0, mag} * {64'd0, RATE_SCALE};
        prod += 128'd1 << 63;
        d = prod[127:64];
        if (q < 0) d = -d;
        return d[31:0];
    endfunction

    task automatic predict_pose(input logic [63:0] t, input logic signed [31:0] vf,
                                input logic signed [31:0] vl, input logic signed [31:0] wr);
        longint c, s, ch, sh, wx, wy, rx, ry, ox, oy, mc, ms, dt;
        logic [31:0] half;
        logic [63:0] gap;
        t_pose p;
        if (!stamp_seen) begin
            last_stamp = t;
            stamp_seen = 1'b1;
            return;
        end
        gap = t - last_stamp;
        if (t <= last_stamp) dt = 0;
        else dt = (gap > 64'hFFFF_FFFF) ? 64'sd4294967295 : longint'(gap);
        last_stamp = t;

        sin_cos(heading, c, s);
        wx = clip(round_shift(vf * c - vl * s, 30), -HALF_TURN, HALF_TURN - 1);
        wy = clip(round_shift(vf * s + vl * c, 30), -HALF_TURN, HALF_TURN - 1);
        track_x = track_x + 48'(travel(wx, dt));
        track_y = track_y + 48'(travel(wy, dt));
        heading = heading + turn(longint'(wr) * dt);

        sin_cos(heading, c, s);
        ox = longint'($signed(mount_reg[REG_OFS_X]));
        oy = longint'($signed(mount_reg[REG_OFS_Y]));
        rx = round_shift(ox * c - oy * s, 22);
        ry = round_shift(ox * s + oy * c, 22);

        // The quaternion takes half of the heading seen as a signed angle.
        half = {heading[31], heading[31:1]};
        sin_cos(half, ch, sh);
        mc = longint'($signed(mount_reg[REG_PITCH_C]));
        ms = longint'($signed(mount_reg[REG_PITCH_S]));

        p.stamp = t;
        p.pos_x = track_x + 48'(rx);
        p.pos_y = track_y + 48'(ry);
        p.pos_z = mount_reg[REG_OFS_Z];
        p.qw = 32'(clip(round_shift(ch * mc, 30), -ONE_Q30, ONE_Q30));
        p.qx = 32'(clip(-round_shift(sh * ms, 30), -ONE_Q30, ONE_Q30));
        p.qy = 32'(clip(round_shift(ch * ms, 30), -ONE_Q30, ONE_Q30));
        p.qz = 32'(clip(round_shift(sh * mc, 30), -ONE_Q30, ONE_Q30));
        pose_q.push_back(p);
    endtask

    always @(posedge i_clk) begin
        t_pose want, got;
        if (!i_rst_n) begin
            mount_reg[REG_OFS_X]   <= 32'd0;
            mount_reg[REG_OFS_Y]   <= 32'd0;
            mount_reg[REG_OFS_Z]   <= 32'd39322;
            mount_reg[REG_PITCH_C] <= 32'd1065364136;
            mount_reg[REG_PITCH_S] <= 32'd133868471;
            heading    = '0;
            track_x    = '0;
            track_y    = '0;
            last_stamp = '0;
            stamp_seen = 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[4:2] <= REG_PITCH_S)
                mount_reg[paddr[4:2]] <= pwdata;
            if (sample_ch.valid && sample_ch.ready)
                predict_pose(sample_ch.stamp_us, sample_ch.velocity_fwd,
                             sample_ch.velocity_lat, sample_ch.yaw_rate);
            if (pose_ch.valid && pose_ch.ready) begin
                o_poses_seen <= o_poses_seen + 1;
                got = {pose_ch.time_out, pose_ch.sensor_pos_x, pose_ch.sensor_pos_y,
                       pose_ch.sensor_pos_z, pose_ch.quat_w, pose_ch.quat_x,
                       pose_ch.quat_y, pose_ch.quat_z};
                if (pose_q.size() == 0) begin
                    strays++;
                    if (mismatches + strays <= 10)
                        $display("pose transfer with nothing predicted: t=%0d", got.stamp);
                end else begin
                    want = pose_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches + strays <= 10) begin
                            $display("pose mismatch at t=%0d", want.stamp);
                            $display("  want t=%h x=%h y=%h z=%h q=%h %h %h %h", want.stamp,
                                     want.pos_x, want.pos_y, want.pos_z,
                                     want.qw, want.qx, want.qy, want.qz);
                            $display("  got  t=%h x=%h y=%h z=%h q=%h %h %h %h", got.stamp,
                                     got.pos_x, got.pos_y, got.pos_z,
                                     got.qw, got.qx, got.qy, got.qz);
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatches + strays;
        o_pending    <= pose_q.size();
    end

    initial begin
        mismatches   = 0;
        strays       = 0;
        o_fail_count = 0;
        o_pending    = 0;
        o_poses_seen = 0;
    end

endmodule

@@ bench/planar_wheel_odometry_integrator_core_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// planar_wheel_odometry_integrator_core_tb: top of the odometry integrator bench
// Drives velocity samples and mount register writes with random idle gaps on
// both channels; the checker beside the block predicts each pose.
// ============================================================================
module planar_wheel_odometry_integrator_core_tb
    import pwoi_pkg::*;
();

    // Index past the last mount register; writes to it must change nothing.
    localparam logic [2:0] REG_SPARE = 3'd7;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    int                poses_seen;
    int                samples_sent;
    int                settings_run;
    logic [63:0]       stamp;
    bit                calm_in;
    bit                calm_out;

    pwoi_in_if  sample_ch ();
    pwoi_out_if pose_ch ();

    planar_wheel_odometry_integrator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_ch),
        .o_res   (pose_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    planar_wheel_odometry_integrator_core_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .sample_ch    (sample_ch),
        .pose_ch      (pose_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_poses_seen (poses_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Pose side: stall for a random number of cycles before each transfer,
    // with occasional calm stretches in which ready simply stays high.
    initial begin
        int n;
        pose_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) calm_out = ~calm_out;
            n = calm_out ? 0 : $urandom_range(0, 6);
            if (n > 0) begin
                pose_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            pose_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(pose_ch.valid && pose_ch.ready));
        end
    end

    // One register write: a setup phase, then an access phase that completes
    // at the edge where pready is seen high.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_mount(input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] oz, input logic [31:0] pc,
                             input logic [31:0] ps);
        write_reg(REG_OFS_X, ox);
        write_reg(REG_OFS_Y, oy);
        write_reg(REG_OFS_Z, oz);
        write_reg(REG_PITCH_C, pc);
        write_reg(REG_PITCH_S, ps);
        write_reg(REG_SPARE, $urandom);
        settings_run++;
    endtask

    // Mount writes only happen with the block idle. The first sample after
    // reset produces no pose, so after the queue drains we also wait out the work
    // of a full sample in case a sample is still being worked on.
    task automatic drain();
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // Presents one sample after a random idle gap and holds it until the
    // transfer. Back-to-back samples keep valid high across the boundary.
    task automatic send_sample(input logic [63:0] t, input logic [31:0] vf,
                               input logic [31:0] vl, input logic [31:0] wr);
        int gap;
        if ($urandom_range(0, 39) == 0) calm_in = ~calm_in;
        gap = calm_in ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.stamp_us     <= t;
        sample_ch.velocity_fwd <= vf;
        sample_ch.velocity_lat <= vl;
        sample_ch.yaw_rate     <= wr;
        do @(posedge i_clk); while (!sample_ch.ready);
        samples_sent++;
    endtask

    task automatic idle_input();
        sample_ch.valid <= 1'b0;
    endtask

    // Velocity-like values: the extremes and zero often, small realistic
    // rates as often, and the full 32-bit range for the rest.
    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3, 4, 5: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            default: return $urandom;
        endcase
    endfunction

    // Stamps mostly advance by a plausible sample period; some repeat or go
    // back, some leap far enough to saturate dt, and a few jump anywhere.
    function automatic logic [63:0] next_stamp(input logic [63:0] t);
        int r;
        r = $urandom_range(0, 99);
        if (r < 78) return t + $urandom_range(0, 200000);
        else if (r < 86) return t;
        else if (r < 92) return t - $urandom_range(1, 100000);
        else if (r < 97) return t + ({$urandom, $urandom} >> $urandom_range(0, 40));
        else return {$urandom, $urandom};
    endfunction

    task automatic random_samples(input int count);
        for (int i = 0; i < count; i++) begin
            stamp = next_stamp(stamp);
            send_sample(stamp, pick_rate(), pick_rate(), pick_rate());
        end
        idle_input();
    endtask

    initial begin
        samples_sent = 0;
        settings_run = 1;
        calm_in      = 0;
        calm_out     = 0;
        i_rst_n                <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        sample_ch.valid        <= 1'b0;
        sample_ch.stamp_us     <= '0;
        sample_ch.velocity_fwd <= '0;
        sample_ch.velocity_lat <= '0;
        sample_ch.yaw_rate     <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset mount. The first sample only latches
        // its stamp. Then come the extremes of every field, a repeated and a
        // backward stamp, gaps long enough to saturate dt at full speed (which
        // also wraps the position), and stamps that toggle every bit.
        send_sample(64'd0, 32'd0, 32'd0, 32'd0);
        send_sample(64'd1000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(64'd1000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(64'd500, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(64'd500 + (64'd1 << 40), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(64'd600 + (64'd1 << 40), 32'h8000_0000, 32'h8000_0000, 32'd0);
        send_sample(64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF);
        send_sample(64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(64'd0, 32'd0, 32'd0, 32'd0);
        send_sample(64'h5555_5555_5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_sample(64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_sample(64'hAAAA_AAAA_AAAB_AAAA, 32'h0001_0000, 32'd0, 32'h0003_243F);
        send_sample(64'hAAAA_AAAA_AAAC_AAAA, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFC_DBC1);
        send_sample(64'hAAAA_AAAA_AAAD_AAAA, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
        send_sample(64'hAAAA_AAAA_AAAD_AAAB, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        stamp = 64'hAAAA_AAAA_AAAD_AAAB;
        random_samples(300);
        drain();

        // Largest mount offsets with a mount quaternion of (1, 1): the
        // products can reach but not pass the edge of the unit range.
        set_mount(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h4000_0000, 32'h4000_0000);
        random_samples(350);
        drain();

        // Most negative offsets and a (-1, -1) quaternion.
        set_mount(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hC000_0000, 32'hC000_0000);
        random_samples(350);
        drain();

        // Arbitrary offsets with an in-range quaternion.
        set_mount($urandom, $urandom, $urandom,
                  32'($urandom_range(0, 1 << 31) - (1 << 30)),
                  32'($urandom_range(0, 1 << 31) - (1 << 30)));
        random_samples(350);
        drain();

        // A zero mount, then a level pitch, to finish.
        set_mount(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        random_samples(150);
        drain();
        set_mount(32'h0001_0000, 32'hFFFF_0000, 32'd39322, 32'h4000_0000, 32'd0);
        random_samples(200);
        drain();

        $display("Sent %0d velocity samples under %0d mount settings.",
                 samples_sent, settings_run);
        $display("Checked %0d sensor poses against the predicted track.", poses_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
